### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

### design/sclcd_pkg.sv
// Types, constants and font ROM for the scaled LCD character writer.
package sclcd_pkg;

    // Display geometry
    localparam logic [4:0] LCD_PAGES  = 5'd8;
    localparam logic [9:0] LCD_WIDTH  = 10'd128;
    localparam logic [7:0] COLUMN_GAP = 8'd4;

    // Font layout
    localparam logic [7:0] CODE_FIRST  = 8'h20;
    localparam logic [7:0] GLYPH_COUNT = 8'd97;
    localparam logic [2:0] GLYPH_COLS  = 3'd7;
    localparam logic [3:0] MAX_V       = 4'd8;
    localparam logic [4:0] MAX_H       = 5'd16;

    // Configuration register indexes
    localparam logic [1:0] REG_V_SCALE = 2'd0;
    localparam logic [1:0] REG_H_SCALE = 2'd1;
    localparam logic [1:0] REG_MIRROR  = 2'd2;

    // Item commands
    localparam logic CMD_DRAW       = 1'b0;
    localparam logic CMD_SET_CURSOR = 1'b1;

    // Glyph: column 0 is the leftmost, bit 0 of a column is the top row
    typedef logic [0:6][7:0] t_glyph;

    // Stretch one font column: each set row becomes vs consecutive pixels.
    function automatic logic [63:0] stretch(logic [7:0] bits, logic [3:0] vs);
        logic [63:0] r;
        logic [6:0]  idx;
        r = '0;
        for (int b = 0; b < 8; b++) begin
            for (int k = 0; k < 8; k++) begin
                idx = 7'(b) * {3'b000, vs} + 7'(k);
                if (bits[b] && (4'(k) < vs)) begin
                    r[idx[5:0]] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic t_glyph font_glyph(logic [6:0] idx);
        t_glyph g;
        case (idx)
            7'd0:  g = 56'h00000000000000;
            7'd1:  g = 56'h0000006F6F0000;
            7'd2:  g = 56'h000B07000B0700;
            7'd3:  g = 56'h14147F147F1414;
            7'd4:  g = 56'h242A2A7F2A2A12;
            7'd5:  g = 56'h47251308645271;
            7'd6:  g = 56'h60968989562050;
            7'd7:  g = 56'h00000B07000000;
            7'd8:  g = 56'h00001C22410000;
            7'd9:  g = 56'h000041221C0000;
            7'd10: g = 56'h004428FE284400;
            7'd11: g = 56'h0008083E080800;
            7'd12: g = 56'h0000D070200000;
            7'd13: g = 56'h00080808080800;
            7'd14: g = 56'h00006060000000;
            7'd15: g = 56'h40201008040201;
            7'd16: g = 56'h3E41414141413E;
            7'd17: g = 56'h0004027F000000;
            7'd18: g = 56'h42615149494542;
            7'd19: g = 56'h414949494D4B31;
            7'd20: g = 56'h20302824227F20;
            7'd21: g = 56'h27454545454539;
            7'd22: g = 56'h30484C4A494830;
            7'd23: g = 56'h03010171090503;
            7'd24: g = 56'h36494949494936;
            7'd25: g = 56'h06094929190906;
            7'd26: g = 56'h00003636000000;
            7'd27: g = 56'h00005636000000;
            7'd28: g = 56'h08141422224141;
            7'd29: g = 56'h24242424242424;
            7'd30: g = 56'h41412222141408;
            7'd31: g = 56'h00020151090600;
            7'd32: g = 56'h3E415D554D117E;
            7'd33: g = 56'h78141211121478;
            7'd34: g = 56'h7F494949494936;
            7'd35: g = 56'h3E414141414122;
            7'd36: g = 56'h7F41414141221C;
            7'd37: g = 56'h7F494949494941;
            7'd38: g = 56'h7F090909090901;
            7'd39: g = 56'h3E414141494938;
            7'd40: g = 56'h7F08080808087F;
            7'd41: g = 56'h0000417F410000;
            7'd42: g = 56'h30404040413F01;
            7'd43: g = 56'h7F201008142241;
            7'd44: g = 56'h7F404040404040;
            7'd45: g = 56'h7F02040804027F;
            7'd46: g = 56'h7F02040810207F;
            7'd47: g = 56'h1C22414141221C;
            7'd48: g = 56'h7F090909090906;
            7'd49: g = 56'h1C22414151225C;
            7'd50: g = 56'h7F090909192946;
            7'd51: g = 56'h26494949494932;
            7'd52: g = 56'h0101017F010101;
            7'd53: g = 56'h1F20404040201F;
            7'd54: g = 56'h0F10204020100F;
            7'd55: g = 56'h7F20100810207F;
            7'd56: g = 56'h41221408142241;
            7'd57: g = 56'h01020478040201;
            7'd58: g = 56'h41615149454341;
            7'd59: g = 56'h00007F41410000;
            7'd60: g = 56'h01020408102040;
            7'd61: g = 56'h000041417F0000;
            7'd62: g = 56'h00040201020400;
            7'd63: g = 56'h40404040404040;
            7'd64: g = 56'h00000103060000;
            7'd65: g = 56'h304A4A4A4A4A7C;
            7'd66: g = 56'h7F444444444438;
            7'd67: g = 56'h38444444444428;
            7'd68: g = 56'h3844444444447F;
            7'd69: g = 56'h38545454545458;
            7'd70: g = 56'h0008087E090900;
            7'd71: g = 56'h0C52525252523E;
            7'd72: g = 56'h7F080404040478;
            7'd73: g = 56'h0000007D000000;
            7'd74: g = 56'h3040404040403D;
            7'd75: g = 56'h7F201018244242;
            7'd76: g = 56'h0000007F400000;
            7'd77: g = 56'h7C040478040478;
            7'd78: g = 56'h7C080404040478;
            7'd79: g = 56'h38444444444438;
            7'd80: g = 56'h7C141414141408;
            7'd81: g = 56'h0814141414147C;
            7'd82: g = 56'h7C080404040408;
            7'd83: g = 56'h48545454545424;
            7'd84: g = 56'h0004043F444400;
            7'd85: g = 56'h3C40404040207C;
            7'd86: g = 56'h0C10204020100C;
            7'd87: g = 56'h7C20100810207C;
            7'd88: g = 56'h44281010102844;
            7'd89: g = 56'h04485020100804;
            7'd90: g = 56'h44645454544C44;
            7'd91: g = 56'h00000836410000;
            7'd92: g = 56'h00000077000000;
            7'd93: g = 56'h00004136080000;
            7'd94: g = 56'h08040408101008;
            7'd95: g = 56'h00000000000000;
            7'd96: g = 56'h00060909090600;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

### design/sclcd_if.sv
// Channel interfaces: character/cursor items in, page writes out.
interface sclcd_char_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] char_code;
    logic [2:0] cursor_page;
    logic [7:0] cursor_column;

    modport source(output valid, cmd, char_code, cursor_page, cursor_column, input ready);
    modport sink(input valid, cmd, char_code, cursor_page, cursor_column, output ready);
endinterface

interface sclcd_wr_if;
    logic       valid;
    logic       ready;
    logic [2:0] page_addr;
    logic [7:0] column_addr;
    logic [7:0] pixel_byte;
    logic [4:0] repeat_count;
    logic       last;

    modport source(output valid, page_addr, column_addr, pixel_byte, repeat_count, last,
                   input ready);
    modport sink(input valid, page_addr, column_addr, pixel_byte, repeat_count, last,
                 output ready);
endinterface

### design/scaled_char_to_lcd_page_writer.sv
// Top level: scaled font character generator producing LCD page writes.
// Usage
//   i_char (sink) takes one item: cmd = set cursor moves the text cursor and
//   yields no write; cmd = draw renders char_code at the cursor. Codes below
//   0x20 or above 0x80 draw a blank glyph. o_wr (source) gives the page writes
//   of a draw: page, column, 8-pixel byte, repeat count, and last on the final
//   write of the character. Config (v_scale, h_scale, mirror) is written on
//   i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// Sequencing
//   A draw produces 8 * vs writes (vs = effective v_scale). For each font
//   column the sequencer first does a setup step in S_COL (stretch + column
//   add), then puts one write per page into the output register in S_EMIT;
//   after the last column a cursor-update step in S_ADV ends the draw. A
//   set-cursor item is applied when it is taken and produces no writes.
//   i_char.ready is high only between items.
// Reset
//   Synchronous, active low: cursor to page 0 column 0, v/h scale 1, mirror
//   off, output register empty.
// Backpressure
//   A stalled write holds in the output register; the sequencer waits on it
//   and resumes on the cycle o_wr.ready takes it.
module scaled_char_to_lcd_page_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data,
    sclcd_char_if.sink  i_char,
    sclcd_wr_if.source  o_wr
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_COL  = 4'b0010,
        S_EMIT = 4'b0100,
        S_ADV  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [3:0] r_v_cfg;
    logic [4:0] r_h_cfg;
    logic       r_mirror;

    // cursor
    logic [2:0] r_cur_page;
    logic [7:0] r_cur_col;

    // per-item working set
    logic [3:0]          r_vs;
    logic [4:0]          r_hs;
    sclcd_pkg::t_glyph   r_glyph;
    logic [7:0]          r_colacc;   // cursor col + c * hs
    logic [7:0]          r_pcol;
    logic [63:0]         r_pix;
    logic [2:0]          r_c;
    logic [2:0]          r_p;
    logic [2:0]          r_page;

    // output register
    logic       r_out_valid;
    logic [2:0] r_out_page;
    logic [7:0] r_out_col;
    logic [7:0] r_out_pix;
    logic [4:0] r_out_rep;
    logic       r_out_last;

    logic        in_acc;
    logic        out_free;
    logic        emit;
    logic        last_page;
    logic        last_col;
    logic [3:0]  eff_v;
    logic [4:0]  eff_h;
    logic [7:0]  code_ofs;
    logic [7:0]  col_bits;
    logic [9:0]  wrap_lim;
    logic        wrap;
    logic [4:0]  adv_page;
    logic [4:0]  sel_page;

    assign i_char.ready = (r_state == S_IDLE);
    assign in_acc       = i_char.valid && i_char.ready;
    assign out_free     = !r_out_valid || o_wr.ready;
    assign emit         = (r_state == S_EMIT) && out_free;
    assign last_page    = ({1'b0, r_p} == (r_vs - 4'd1));
    assign last_col     = (r_c == sclcd_pkg::GLYPH_COLS);

    // zero acts as 1, oversize saturates
    assign eff_v = (r_v_cfg == 4'd0) ? 4'd1 :
                   (r_v_cfg > sclcd_pkg::MAX_V) ? sclcd_pkg::MAX_V : r_v_cfg;
    assign eff_h = (r_h_cfg == 5'd0) ? 5'd1 :
                   (r_h_cfg > sclcd_pkg::MAX_H) ? sclcd_pkg::MAX_H : r_h_cfg;

    assign code_ofs = i_char.char_code - sclcd_pkg::CODE_FIRST;
    // spacing column (c == 7) is blank
    assign col_bits = last_col ? 8'h00 : r_glyph[r_c];

    // line wrap: advanced column vs WIDTH - 8*hs, signed
    assign wrap_lim = sclcd_pkg::LCD_WIDTH - {2'b00, r_hs, 3'b000};
    assign wrap     = $signed({2'b00, r_colacc}) > $signed(wrap_lim);
    assign adv_page = {2'b00, r_cur_page} + {1'b0, r_vs};
    assign sel_page = wrap ? adv_page : {2'b00, r_cur_page};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_char.cmd == sclcd_pkg::CMD_DRAW)) begin
                    n_state = S_COL;
                end
            end
            S_COL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (emit && last_page) begin
                    n_state = last_col ? S_ADV : S_COL;
                end
            end
            S_ADV: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_v_cfg     <= 4'd1;
            r_h_cfg     <= 5'd1;
            r_mirror    <= 1'b0;
            r_cur_page  <= 3'd0;
            r_cur_col   <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sclcd_pkg::REG_V_SCALE: r_v_cfg  <= i_cfg_data[3:0];
                    sclcd_pkg::REG_H_SCALE: r_h_cfg  <= i_cfg_data;
                    sclcd_pkg::REG_MIRROR:  r_mirror <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (in_acc && (i_char.cmd == sclcd_pkg::CMD_SET_CURSOR)) begin
                r_cur_page <= i_char.cursor_page;
                r_cur_col  <= i_char.cursor_column;
            end else if (r_state == S_ADV) begin
                r_cur_col  <= wrap ? 8'd0 : r_colacc;
                r_cur_page <= (sel_page >= sclcd_pkg::LCD_PAGES) ? 3'd0 : sel_page[2:0];
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_wr.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_vs     <= eff_v;
            r_hs     <= eff_h;
            r_colacc <= r_cur_col;
            r_c      <= 3'd0;
            r_glyph  <= (code_ofs < sclcd_pkg::GLYPH_COUNT) ?
                        sclcd_pkg::font_glyph(code_ofs[6:0]) : '0;
        end

        if (r_state == S_COL) begin
            r_pix    <= sclcd_pkg::stretch(col_bits, r_vs);
            r_pcol   <= r_colacc + (r_mirror ? sclcd_pkg::COLUMN_GAP : 8'd0);
            r_colacc <= r_colacc + {3'b000, r_hs};
            r_p      <= 3'd0;
            r_page   <= r_cur_page;
        end

        if (emit) begin
            r_out_page <= r_page;
            r_out_col  <= r_pcol;
            r_out_pix  <= r_pix[7:0];
            r_out_rep  <= r_hs;
            r_out_last <= last_col && last_page;
            r_pix      <= {8'h00, r_pix[63:8]};
            r_page     <= r_page + 3'd1;
            r_p        <= r_p + 3'd1;
            if (last_page && !last_col) begin
                r_c <= r_c + 3'd1;
            end
        end
    end

    assign o_wr.valid        = r_out_valid;
    assign o_wr.page_addr    = r_out_page;
    assign o_wr.column_addr  = r_out_col;
    assign o_wr.pixel_byte   = r_out_pix;
    assign o_wr.repeat_count = r_out_rep;
    assign o_wr.last         = r_out_last;

endmodule

### design/sclcd_checker.sv
// Port-level checker for the scaled LCD character writer, with its bind.
`include "assert_macros.svh"

module sclcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_page,
    input logic [7:0] i_out_col,
    input logic [7:0] i_out_pix,
    input logic [4:0] i_out_rep,
    input logic       i_out_last
);

    // stalled write stays offered
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "write dropped while stalled")

    // stalled write keeps its payload
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_page) && $stable(i_out_col) && $stable(i_out_pix) && $stable(i_out_rep) && $stable(i_out_last), "write payload changed while stalled")

    // repeat count is the clamped h_scale
    `ASSERT_NOW(a_rep_range, i_clk, i_rst_n, i_out_valid, (i_out_rep != 5'd0) && (i_out_rep <= 5'd16), "repeat count out of range")

    // no new item is taken in the middle of a character
    `ASSERT_NOW(a_busy_mid_char, i_clk, i_rst_n, i_out_valid && !i_out_last, !i_in_ready, "input ready during a character")

endmodule

bind scaled_char_to_lcd_page_writer sclcd_checker u_sclcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_char.ready),
    .i_out_valid (o_wr.valid),
    .i_out_ready (o_wr.ready),
    .i_out_page  (o_wr.page_addr),
    .i_out_col   (o_wr.column_addr),
    .i_out_pix   (o_wr.pixel_byte),
    .i_out_rep   (o_wr.repeat_count),
    .i_out_last  (o_wr.last)
);

### sim/tb_scaled_char_to_lcd_page_writer.sv
// Self-checking testbench: scaled font character writer, predicted page writes vs. DUT output.
`timescale 1ns / 100ps

module tb_scaled_char_to_lcd_page_writer;

    // Idle cycles (nothing accepted on either channel) before the run is declared hung.
    // Covers the long receiver hold-off, drain waits and the largest sender gaps.
    localparam int WATCHDOG_LIMIT = 3000;
    // Receiver hold-off length for the backpressure stretch
    localparam int RX_HOLD_CYCLES = 400;
    // Settle time after the last write: a draw ends with a cursor-update cycle
    localparam int SETTLE_CYCLES  = 12;

    // Font: 7 columns per glyph, column 0 in the top byte, bit 0 of a column is the top row
    localparam logic [55:0] FONT_ROM [0:96] = '{
        56'h00000000000000, 56'h0000006F6F0000, 56'h000B07000B0700, 56'h14147F147F1414,
        56'h242A2A7F2A2A12, 56'h47251308645271, 56'h60968989562050, 56'h00000B07000000,
        56'h00001C22410000, 56'h000041221C0000, 56'h004428FE284400, 56'h0008083E080800,
        56'h0000D070200000, 56'h00080808080800, 56'h00006060000000, 56'h40201008040201,
        56'h3E41414141413E, 56'h0004027F000000, 56'h42615149494542, 56'h414949494D4B31,
        56'h20302824227F20, 56'h27454545454539, 56'h30484C4A494830, 56'h03010171090503,
        56'h36494949494936, 56'h06094929190906, 56'h00003636000000, 56'h00005636000000,
        56'h08141422224141, 56'h24242424242424, 56'h41412222141408, 56'h00020151090600,
        56'h3E415D554D117E, 56'h78141211121478, 56'h7F494949494936, 56'h3E414141414122,
        56'h7F41414141221C, 56'h7F494949494941, 56'h7F090909090901, 56'h3E414141494938,
        56'h7F08080808087F, 56'h0000417F410000, 56'h30404040413F01, 56'h7F201008142241,
        56'h7F404040404040, 56'h7F02040804027F, 56'h7F02040810207F, 56'h1C22414141221C,
        56'h7F090909090906, 56'h1C22414151225C, 56'h7F090909192946, 56'h26494949494932,
        56'h0101017F010101, 56'h1F20404040201F, 56'h0F10204020100F, 56'h7F20100810207F,
        56'h41221408142241, 56'h01020478040201, 56'h41615149454341, 56'h00007F41410000,
        56'h01020408102040, 56'h000041417F0000, 56'h00040201020400, 56'h40404040404040,
        56'h00000103060000, 56'h304A4A4A4A4A7C, 56'h7F444444444438, 56'h38444444444428,
        56'h3844444444447F, 56'h38545454545458, 56'h0008087E090900, 56'h0C52525252523E,
        56'h7F080404040478, 56'h0000007D000000, 56'h3040404040403D, 56'h7F201018244242,
        56'h0000007F400000, 56'h7C040478040478, 56'h7C080404040478, 56'h38444444444438,
        56'h7C141414141408, 56'h0814141414147C, 56'h7C080404040408, 56'h48545454545424,
        56'h0004043F444400, 56'h3C40404040207C, 56'h0C10204020100C, 56'h7C20100810207C,
        56'h44281010102844, 56'h04485020100804, 56'h44645454544C44, 56'h00000836410000,
        56'h00000077000000, 56'h00004136080000, 56'h08040408101008, 56'h00000000000000,
        56'h00060909090600
    };

    // One LCD page write as seen on the output channel
    typedef struct packed {
        logic [2:0] page_addr;
        logic [7:0] column_addr;
        logic [7:0] pixel_byte;
        logic [4:0] repeat_count;
        logic       last;
    } t_page_write;

    // Receiver ready patterns
    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PATTERN, RX_SPARSE} t_rx_mode;

    // Tracks cursor and scale registers, expands each character into its page writes
    // and checks the DUT writes against them in order.
    class t_page_write_scoreboard;
        t_page_write expected_writes[$];
        logic [3:0]  v_scale;
        logic [4:0]  h_scale;
        logic        mirror;
        logic [2:0]  cursor_page;
        logic [7:0]  cursor_column;
        int          errors;
        int          writes_checked;
        int          chars_drawn;
        int          cursor_moves;

        function new();
            v_scale        = 4'd1;
            h_scale        = 5'd1;
            mirror         = 1'b0;
            cursor_page    = '0;
            cursor_column  = '0;
            errors         = 0;
            writes_checked = 0;
            chars_drawn    = 0;
            cursor_moves   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [4:0] data);
            case (idx)
                sclcd_pkg::REG_V_SCALE: v_scale = data[3:0];
                sclcd_pkg::REG_H_SCALE: h_scale = data;
                sclcd_pkg::REG_MIRROR:  mirror  = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction

        // Called for every accepted input item
        function void note_item(logic cmd, logic [7:0] code, logic [2:0] pg, logic [7:0] col);
            int          vs;
            int          hs;
            int          advance;
            logic [7:0]  glyph_idx;
            logic [7:0]  bits;
            logic [7:0]  column;
            logic [7:0]  next_col;
            logic [3:0]  next_page;
            logic [55:0] glyph;
            logic [63:0] tall;
            t_page_write w;

            if (cmd == sclcd_pkg::CMD_SET_CURSOR) begin
                cursor_page   = pg;
                cursor_column = col;
                cursor_moves++;
                return;
            end

            // zero acts as 1, oversize saturates
            vs = (v_scale == 0) ? 1 :
                 (v_scale > sclcd_pkg::MAX_V) ? int'(sclcd_pkg::MAX_V) : int'(v_scale);
            hs = (h_scale == 0) ? 1 :
                 (h_scale > sclcd_pkg::MAX_H) ? int'(sclcd_pkg::MAX_H) : int'(h_scale);

            // codes outside the font give an index past the table and render blank
            glyph_idx = code - sclcd_pkg::CODE_FIRST;
            glyph     = (glyph_idx < sclcd_pkg::GLYPH_COUNT) ? FONT_ROM[glyph_idx] : '0;

            // 7 font columns then one blank spacing column
            for (int c = 0; c < 8; c++) begin
                bits = 8'h00;
                if (c < 7) bits = glyph[8 * (6 - c) +: 8];
                tall = '0;
                for (int b = 0; b < 8; b++) begin
                    for (int k = 0; k < vs; k++) begin
                        if (bits[b]) tall[b * vs + k] = 1'b1;
                    end
                end
                column = cursor_column + 8'(c * hs);
                if (mirror) column = column + sclcd_pkg::COLUMN_GAP;
                for (int p = 0; p < vs; p++) begin
                    w.page_addr    = cursor_page + 3'(p);
                    w.column_addr  = column;
                    w.pixel_byte   = tall[8 * p +: 8];
                    w.repeat_count = 5'(hs);
                    w.last         = (c == 7) && (p == vs - 1);
                    expected_writes.push_back(w);
                end
            end

            // cursor advance, line wrap (signed compare), page wrap
            advance   = 8 * hs;
            next_col  = cursor_column + 8'(advance);
            next_page = {1'b0, cursor_page};
            if (int'(next_col) > int'(sclcd_pkg::LCD_WIDTH) - advance) begin
                next_col  = 8'd0;
                next_page = {1'b0, cursor_page} + 4'(vs);
            end
            if (next_page >= sclcd_pkg::LCD_PAGES) next_page = 4'd0;
            cursor_page   = next_page[2:0];
            cursor_column = next_col;
            chars_drawn++;
        endfunction

        // Called for every accepted output item
        function void check_write(t_page_write got);
            t_page_write want;
            if (expected_writes.size() == 0) begin
                errors++;
                $display("%0t: unexpected write: page %0d col %0d pix %02h rep %0d last %0b",
                         $time, got.page_addr, got.column_addr, got.pixel_byte,
                         got.repeat_count, got.last);
                return;
            end
            want = expected_writes.pop_front();
            writes_checked++;
            if (got.page_addr !== want.page_addr || got.column_addr !== want.column_addr ||
                got.pixel_byte !== want.pixel_byte || got.repeat_count !== want.repeat_count ||
                got.last !== want.last) begin
                errors++;
                $display("%0t: mismatch, expected page %0d col %0d pix %02h rep %0d last %0b",
                         $time, want.page_addr, want.column_addr, want.pixel_byte,
                         want.repeat_count, want.last);
                $display("%0t:           actual   page %0d col %0d pix %02h rep %0d last %0b",
                         $time, got.page_addr, got.column_addr, got.pixel_byte,
                         got.repeat_count, got.last);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [4:0] i_cfg_data;

    sclcd_char_if char_ch ();
    sclcd_wr_if   wr_ch ();

    t_page_write_scoreboard sb = new();

    int burst_left;       // items left in the current sender burst
    int settings_used;    // register settings the run went through
    int hold_requests;    // written by the stimulus only
    int hold_served;      // written by the receiver only

    scaled_char_to_lcd_page_writer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_char     (char_ch),
        .o_wr       (wr_ch)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Sender: offers one item, waits for the handshake, notes it in the
    // scoreboard. Bursts of random length are followed by random gaps;
    // valid stays high between items of a burst.
    // ------------------------------------------------------------------
    task automatic offer_item(input logic cmd, input logic [7:0] code,
                              input logic [2:0] pg, input logic [7:0] col);
        char_ch.valid         <= 1'b1;
        char_ch.cmd           <= cmd;
        char_ch.char_code     <= code;
        char_ch.cursor_page   <= pg;
        char_ch.cursor_column <= col;
        do @(posedge i_clk); while (!char_ch.ready);
        sb.note_item(cmd, code, pg, col);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            char_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    // Stop offering and wait until every expected write has come out, then let the
    // trailing cursor-update cycle pass so the block is truly idle.
    task automatic drain_writes();
        char_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Back-to-back writes of all three registers; write enable drops after the last.
    // Raw 5-bit data: upper bits beyond each register width are dropped by the block.
    task automatic load_scales(input logic [4:0] v, input logic [4:0] h, input logic [4:0] m);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sclcd_pkg::REG_V_SCALE;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_reg(sclcd_pkg::REG_V_SCALE, v);
        i_cfg_idx  <= sclcd_pkg::REG_H_SCALE;
        i_cfg_data <= h;
        @(posedge i_clk);
        sb.set_reg(sclcd_pkg::REG_H_SCALE, h);
        i_cfg_idx  <= sclcd_pkg::REG_MIRROR;
        i_cfg_data <= m;
        @(posedge i_clk);
        sb.set_reg(sclcd_pkg::REG_MIRROR, m);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Output monitor: every accepted page write goes to the scoreboard
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_page_write seen;
        if (i_rst_n && wr_ch.valid && wr_ch.ready) begin
            seen.page_addr    = wr_ch.page_addr;
            seen.column_addr  = wr_ch.column_addr;
            seen.pixel_byte   = wr_ch.pixel_byte;
            seen.repeat_count = wr_ch.repeat_count;
            seen.last         = wr_ch.last;
            sb.check_write(seen);
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a pattern that changes every so often:
    // always ready, coin flip, a rotating bit mask, or rarely ready.
    // On request it holds ready low for a long stretch so the block
    // backs up into its input.
    // ------------------------------------------------------------------
    initial begin
        t_rx_mode    mode;
        int          mode_left;
        int          hold_left;
        logic [15:0] mask;
        mode      = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        mask      = 16'hFFFF;
        hold_served = 0;
        wr_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                wr_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 150);
                    mask      = 16'($urandom);
                end
                mode_left--;
                case (mode)
                    RX_FREE:    wr_ch.ready <= 1'b1;
                    RX_COIN:    wr_ch.ready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: begin
                        wr_ch.ready <= mask[0];
                        mask = {mask[0], mask[15:1]};
                    end
                    default:    wr_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
            @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends a hung run after too many cycles without a handshake
    // ------------------------------------------------------------------
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((char_ch.valid && char_ch.ready) || (wr_ch.valid && wr_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: timeout, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int pick;

        // every input known from time zero
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = sclcd_pkg::REG_V_SCALE;
        i_cfg_data            = '0;
        char_ch.valid         = 1'b0;
        char_ch.cmd           = sclcd_pkg::CMD_DRAW;
        char_ch.char_code     = '0;
        char_ch.cursor_page   = '0;
        char_ch.cursor_column = '0;
        burst_left            = 0;
        settings_used         = 0;
        hold_requests         = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- Directed: reset scales, font edges, out-of-range codes, wraps ---
        load_scales(5'd1, 5'd1, 5'd0);
        // first and last code in the font, then just below and just above it
        offer_item(sclcd_pkg::CMD_DRAW, 8'h20, 3'd0, 8'd0);
        offer_item(sclcd_pkg::CMD_DRAW, 8'h80, 3'd0, 8'd0);
        offer_item(sclcd_pkg::CMD_DRAW, 8'h1F, 3'd0, 8'd0);
        offer_item(sclcd_pkg::CMD_DRAW, 8'h81, 3'd0, 8'd0);
        // ignored cursor fields all ones
        offer_item(sclcd_pkg::CMD_DRAW, 8'h00, 3'd7, 8'hFF);
        offer_item(sclcd_pkg::CMD_DRAW, 8'hFF, 3'd0, 8'd0);
        offer_item(sclcd_pkg::CMD_DRAW, 8'h41, 3'd0, 8'd0);
        // column addresses wrap past 255
        offer_item(sclcd_pkg::CMD_SET_CURSOR, 8'h00, 3'd7, 8'd255);
        offer_item(sclcd_pkg::CMD_DRAW, 8'h7F, 3'd0, 8'd0);
        // advance lands past the line end
        offer_item(sclcd_pkg::CMD_SET_CURSOR, 8'h00, 3'd0, 8'd120);
        offer_item(sclcd_pkg::CMD_DRAW, 8'h55, 3'd0, 8'd0);
        // line wrap from the last page
        offer_item(sclcd_pkg::CMD_SET_CURSOR, 8'h00, 3'd7, 8'd121);
        offer_item(sclcd_pkg::CMD_DRAW, 8'h40, 3'd0, 8'd0);
        // char code ignored on set cursor
        offer_item(sclcd_pkg::CMD_SET_CURSOR, 8'hFF, 3'd0, 8'd0);

        // zero scales act as 1, mirror gap on, gap pushes the column past 255
        drain_writes();
        load_scales(5'd0, 5'd0, 5'd1);
        offer_item(sclcd_pkg::CMD_DRAW, 8'h7E, 3'd0, 8'd0);
        offer_item(sclcd_pkg::CMD_SET_CURSOR, 8'h00, 3'd5, 8'd250);
        offer_item(sclcd_pkg::CMD_DRAW, 8'h41, 3'd0, 8'd0);

        // largest legal scales: 64 writes, pages wrap mod 8, every advance wraps the line
        drain_writes();
        load_scales(5'd8, 5'd16, 5'd1);
        offer_item(sclcd_pkg::CMD_DRAW, 8'h26, 3'd0, 8'd0);   // glyph with the top bit set
        offer_item(sclcd_pkg::CMD_SET_CURSOR, 8'h00, 3'd6, 8'd0);
        offer_item(sclcd_pkg::CMD_DRAW, 8'h57, 3'd0, 8'd0);

        // oversized scales saturate
        drain_writes();
        load_scales(5'd15, 5'd31, 5'd0);
        offer_item(sclcd_pkg::CMD_DRAW, 8'h4D, 3'd0, 8'd0);
        offer_item(sclcd_pkg::CMD_DRAW, 8'h5A, 3'd0, 8'd0);

        // --- Random: six settings, 25 items each ---
        for (int ph = 0; ph < 6; ph++) begin
            drain_writes();
            if (ph == 0)
                load_scales(5'd2, 5'd2, 5'd0);
            else
                load_scales(5'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                            5'($urandom_range(0, 31)));
            // one long receiver hold-off while the sender keeps offering
            if (ph == 1) hold_requests++;
            repeat (25) begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    offer_item(sclcd_pkg::CMD_SET_CURSOR, 8'($urandom), 3'($urandom),
                               8'($urandom));
                else if (pick < 8)
                    offer_item(sclcd_pkg::CMD_DRAW, 8'($urandom_range(32, 128)),
                               3'($urandom), 8'($urandom));
                else
                    offer_item(sclcd_pkg::CMD_DRAW, 8'($urandom), 3'($urandom),
                               8'($urandom));
            end
        end

        // all stimulus taken: wait for the last writes, then a quiet tail to
        // catch anything extra
        char_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Covered %0d characters and %0d cursor moves over %0d scale/mirror settings,",
                 sb.chars_drawn, sb.cursor_moves, settings_used);
        $display("with %0d page writes checked and %0d mismatches.",
                 sb.writes_checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/sclcd_pkg.sv
design/sclcd_if.sv
design/scaled_char_to_lcd_page_writer.sv
design/sclcd_checker.sv
sim/tb_scaled_char_to_lcd_page_writer.sv
